// File: hdl/pct_pkg.sv
`timescale 1ns / 1ps
package pct_pkg;

  localparam int SLOTS  = 64;
  localparam int GROUPS = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ID_W   = 32;
  localparam int CAP_W  = 64;
  localparam int CNT_W  = 4;
  localparam int GCNT_W = 3;
  localparam int GRP_W  = 32;

  localparam int IN_W   = 264;
  localparam int OUT_W  = 232;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ASSIGN = 2'd1,
    OP_GET    = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BADCOUNT = 2'd1,
    STAT_MISSING  = 2'd2,
    STAT_DENIED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [1:0]       pad;
    logic [GRP_W-1:0] group_d;
    logic [GRP_W-1:0] group_c;
    logic [GRP_W-1:0] group_b;
    logic [GRP_W-1:0] group_a;
    logic [CNT_W-1:0] group_count;
    logic [CAP_W-1:0] cap_mask;
    logic [ID_W-1:0]  user_id;
    logic [ID_W-1:0]  proc_key;
    op_t              opcode;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic [GRP_W-1:0]  found_group_d;
    logic [GRP_W-1:0]  found_group_c;
    logic [GRP_W-1:0]  found_group_b;
    logic [GRP_W-1:0]  found_group_a;
    logic [GCNT_W-1:0] found_group_count;
    logic [CAP_W-1:0]  found_cap_mask;
    logic [ID_W-1:0]   found_user_id;
    status_t           status;
  } out_item_t;

  typedef struct packed {
    logic [GROUPS-1:0][GRP_W-1:0] groups;
    logic [GCNT_W-1:0]            group_count;
    logic [CAP_W-1:0]             caps;
    logic [ID_W-1:0]              user;
  } cred_t;

  typedef struct packed {
    logic              clear;
    logic              write;
    logic [SLOT_W-1:0] idx;
  } lk_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } lk_res_t;

endpackage

// File: hdl/pct_lookup.sv
`timescale 1ns / 1ps
module pct_lookup (
  input  logic                  clk,
  input  logic                  rst,
  input  pct_pkg::lk_cmd_t      cmd,
  input  logic [31:0]           pid,
  output pct_pkg::lk_res_t      res
);
  import pct_pkg::*;

  logic [SLOTS-1:0]           valid;
  logic [SLOTS-1:0][ID_W-1:0] owner;
  logic [SLOTS-1:0]           match_q;
  logic [SLOTS-1:0]           free_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.clear) begin
      valid <= '0;
    end else if (cmd.write) begin
      valid[cmd.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      owner[cmd.idx] <= pid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      match_q[i] <= valid[i] && (owner[i] == pid);
      free_q[i]  <= !valid[i];
    end
  end

  // lowest set bit wins
  always_comb begin
    res = '0;
    res.hit  = |match_q;
    res.free = |free_q;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        res.hit_idx = SLOT_W'(i);
      end
      if (free_q[i]) begin
        res.free_idx = SLOT_W'(i);
      end
    end
  end

endmodule

// File: hdl/process_credential_table_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Bits  Content
// s_axis   in   264   opcode, proc_key, user_id, cap_mask, group_count, group_a..d
// m_axis   out  232   status, found_user_id, found_cap_mask, found_group_count,
//                     found_group_a..d
//
// One item at a time: accept, owner match (registered), resolve, and for a get
// or check that hits, one read of the credential memory.
// Clear, assign and a miss finish in the resolve step; get and check that hit finish in the read step.
// Reset clears the slot valid bits at once; no clearing pass.
// A result that is not taken holds the block in its last step.
module process_credential_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, proc_key, user_id, cap_mask, group_count, group_a, group_b,
  // group_c, group_d, zero pad
  input  logic [263:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, found_user_id, found_cap_mask, found_group_count, found_group_a,
  // found_group_b, found_group_c, found_group_d, zero pad
  output logic [231:0] m_tdata
);
  import pct_pkg::*;

  state_t    state, state_next;
  in_item_t  item;
  lk_cmd_t   lk_cmd;
  lk_res_t   lk_res;
  cred_t     mem [SLOTS];
  cred_t     rd_data;
  cred_t     wr_data;
  out_item_t res_d;
  logic      load_out;
  logic      out_free;
  logic      mem_we;
  logic [3:0][GRP_W-1:0] in_grp;
  logic [3:0][GRP_W-1:0] out_grp;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  pct_lookup u_lookup (
    .clk (clk),
    .rst (rst),
    .cmd (lk_cmd),
    .pid (item.proc_key),
    .res (lk_res)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= in_item_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[lk_cmd.idx] <= wr_data;
    end
    rd_data <= mem[lk_res.hit_idx];
  end

  always_comb begin
    in_grp = {item.group_d, item.group_c, item.group_b, item.group_a};
    wr_data = '0;
    wr_data.user        = item.user_id;
    wr_data.caps        = item.cap_mask;
    wr_data.group_count = item.group_count[GCNT_W-1:0];
    for (int g = 0; g < GROUPS; g++) begin
      wr_data.groups[g] = (CNT_W'(g) < item.group_count) ? in_grp[g] : '0;
    end
    out_grp = '0;
    for (int g = 0; g < GROUPS; g++) begin
      out_grp[g] = rd_data.groups[g];
    end
  end

  always_comb begin
    state_next = state;
    lk_cmd     = '0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    res_d      = '0;
    res_d.status = STAT_OK;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        case (item.opcode)
          OP_CLEAR: begin
            if (out_free) begin
              lk_cmd.clear = 1'b1;
              load_out     = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          OP_ASSIGN: begin
            if (item.group_count > CNT_W'(GROUPS)) begin
              res_d.status = STAT_BADCOUNT;
            end else if (lk_res.hit || lk_res.free) begin
              lk_cmd.idx = lk_res.hit ? lk_res.hit_idx : lk_res.free_idx;
              if (out_free) begin
                lk_cmd.write = 1'b1;
                mem_we       = 1'b1;
              end
            end else begin
              res_d.status = STAT_MISSING;
            end
            if (out_free) begin
              load_out   = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            if (lk_res.hit) begin
              state_next = ST_READ;
            end else if (out_free) begin
              res_d.status = STAT_MISSING;
              load_out     = 1'b1;
              state_next   = ST_IDLE;
            end
          end
        endcase
      end
      ST_READ: begin
        if (item.opcode == OP_GET) begin
          res_d.found_user_id     = rd_data.user;
          res_d.found_cap_mask    = rd_data.caps;
          res_d.found_group_count = rd_data.group_count;
          res_d.found_group_a     = out_grp[0];
          res_d.found_group_b     = out_grp[1];
          res_d.found_group_c     = out_grp[2];
          res_d.found_group_d     = out_grp[3];
        end else if ((rd_data.caps & item.cap_mask) != item.cap_mask) begin
          res_d.status = STAT_DENIED;
        end
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= OUT_W'(res_d);
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import pct_pkg::*;

  localparam int LIMIT = 200000;
  localparam int POOL_IDS = 72;
  localparam int POOL_CAPS = 8;
  localparam int RANDOM_ITEMS = 560;

  class credential_scoreboard;
    bit              valid [SLOTS];
    logic [ID_W-1:0] owner [SLOTS];
    logic [ID_W-1:0] user [SLOTS];
    logic [CAP_W-1:0] caps [SLOTS];
    logic [GCNT_W-1:0] gcount [SLOTS];
    logic [GRP_W-1:0] groups [SLOTS][GROUPS];
    out_item_t       expected_replies [$];
    int              failures = 0;

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
    endfunction

    function int find_owner(logic [ID_W-1:0] pid);
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && owner[i] == pid) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < SLOTS; i++)
        if (!valid[i]) return i;
      return -1;
    endfunction

    function out_item_t predict_reply(in_item_t it);
      out_item_t r;
      int s;
      logic [GRP_W-1:0] grp [4];
      logic [GRP_W-1:0] fg [4];
      r = '0;
      r.status = STAT_OK;
      grp[0] = it.group_a;
      grp[1] = it.group_b;
      grp[2] = it.group_c;
      grp[3] = it.group_d;
      foreach (fg[g]) fg[g] = '0;
      case (it.opcode)
        OP_CLEAR: begin
          foreach (valid[i]) valid[i] = 1'b0;
        end
        OP_ASSIGN: begin
          if (it.group_count > GROUPS) begin
            r.status = STAT_BADCOUNT;
          end else begin
            s = find_owner(it.proc_key);
            if (s < 0) s = find_free();
            if (s < 0) begin
              r.status = STAT_MISSING;
            end else begin
              valid[s] = 1'b1;
              owner[s] = it.proc_key;
              user[s] = it.user_id;
              caps[s] = it.cap_mask;
              gcount[s] = it.group_count[GCNT_W-1:0];
              for (int g = 0; g < GROUPS; g++)
                groups[s][g] = (g < it.group_count) ? grp[g] : '0;
            end
          end
        end
        default: begin
          s = find_owner(it.proc_key);
          if (s < 0) begin
            r.status = STAT_MISSING;
          end else if (it.opcode == OP_GET) begin
            r.found_user_id = user[s];
            r.found_cap_mask = caps[s];
            r.found_group_count = gcount[s];
            for (int g = 0; g < GROUPS && g < 4; g++) fg[g] = groups[s][g];
            r.found_group_a = fg[0];
            r.found_group_b = fg[1];
            r.found_group_c = fg[2];
            r.found_group_d = fg[3];
          end else if ((caps[s] & it.cap_mask) != it.cap_mask) begin
            r.status = STAT_DENIED;
          end
        end
      endcase
      return r;
    endfunction

    function void note_command(in_item_t it);
      expected_replies.push_back(predict_reply(it));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, got);
        failures++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("found_user_id", 64'(want.found_user_id), 64'(got.found_user_id));
      compare_field("found_cap_mask", want.found_cap_mask, got.found_cap_mask);
      compare_field("found_group_count", 64'(want.found_group_count),
                    64'(got.found_group_count));
      compare_field("found_group_a", 64'(want.found_group_a), 64'(got.found_group_a));
      compare_field("found_group_b", 64'(want.found_group_b), 64'(got.found_group_b));
      compare_field("found_group_c", 64'(want.found_group_c), 64'(got.found_group_c));
      compare_field("found_group_d", 64'(want.found_group_d), 64'(got.found_group_d));
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [263:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [231:0] m_tdata;

  credential_scoreboard sb = new();

  logic [ID_W-1:0]  pool_ids [POOL_IDS];
  logic [CAP_W-1:0] pool_caps [POOL_CAPS];
  int burst_left = 0;
  int cycles = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  process_credential_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_tick <= $urandom_range(20, 120);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (stall_tick % 5) != 0;
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_response(out_item_t'(m_tdata));
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(op_t op, logic [31:0] pid, logic [31:0] uid,
                                         logic [63:0] cm, logic [3:0] cnt,
                                         logic [31:0] ga, logic [31:0] gb,
                                         logic [31:0] gc, logic [31:0] gd);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.proc_key = pid;
    it.user_id = uid;
    it.cap_mask = cm;
    it.group_count = cnt;
    it.group_a = ga;
    it.group_b = gb;
    it.group_c = gc;
    it.group_d = gd;
    return it;
  endfunction

  function automatic in_item_t random_item();
    int pick;
    op_t op;
    logic [31:0] pid;
    logic [63:0] cm;
    logic [3:0] cnt;
    pick = $urandom_range(0, 99);
    if (pick < 2) op = OP_CLEAR;
    else if (pick < 45) op = OP_ASSIGN;
    else if (pick < 72) op = OP_GET;
    else op = OP_CHECK;
    pid = ($urandom_range(0, 9) < 8) ? pool_ids[$urandom_range(0, POOL_IDS - 1)] : $urandom;
    cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 4));
    pick = $urandom_range(0, 9);
    if (op == OP_CHECK) begin
      if (pick < 6) cm = pool_caps[$urandom_range(0, POOL_CAPS - 1)] & rand64();
      else if (pick < 7) cm = '0;
      else cm = rand64();
    end else begin
      cm = (pick < 7) ? pool_caps[$urandom_range(0, POOL_CAPS - 1)] : rand64();
    end
    return make_item(op, pid, $urandom, cm, cnt, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_command(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
    s_tdata <= it;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(it);
  endtask

  initial begin
    logic [31:0] ones;
    logic [63:0] wide;
    ones = '1;
    wide = '1;
    foreach (pool_ids[i]) pool_ids[i] = $urandom;
    pool_ids[0] = '0;
    pool_ids[1] = ones;
    foreach (pool_caps[i]) pool_caps[i] = rand64();
    pool_caps[0] = wide;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_command(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CHECK, ones, 0, wide, 0, 0, 0, 0, 0));
    send_command(make_item(OP_ASSIGN, 0, ones, wide, 4, ones, ones, ones, ones));
    send_command(make_item(OP_ASSIGN, ones, 0, 0, 0, ones, ones, ones, ones));
    send_command(make_item(OP_ASSIGN, 1, ones, wide, 5, ones, ones, ones, ones));
    send_command(make_item(OP_ASSIGN, 2, ones, wide, 15, ones, ones, ones, ones));
    send_command(make_item(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, ones, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, 1, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_ASSIGN, 3, $urandom, rand64(), 1, $urandom, $urandom,
                           $urandom, $urandom));
    send_command(make_item(OP_ASSIGN, 4, $urandom, rand64(), 2, $urandom, $urandom,
                           $urandom, $urandom));
    send_command(make_item(OP_ASSIGN, 5, $urandom, rand64(), 3, $urandom, $urandom,
                           $urandom, $urandom));
    send_command(make_item(OP_ASSIGN, 0, 32'h1234_5678, 64'h00FF_00FF_00FF_00FF, 2,
                           32'hA5A5_A5A5, 32'h5A5A_5A5A, ones, ones));
    send_command(make_item(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CHECK, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CHECK, ones, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CHECK, ones, 0, 1, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CHECK, 0, 0, 64'h0001_0080_00FF_0001, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CHECK, 0, 0, wide, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, 3, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, 4, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, 5, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_GET, 0, 0, 0, 0, 0, 0, 0, 0));

    // fill every slot, then hit a full table
    for (int n = 0; n < SLOTS; n++) begin
      send_command(make_item(OP_ASSIGN, 32'h0001_0000 + 32'(n), $urandom, rand64(),
                             4'($urandom_range(0, 4)), $urandom, $urandom, $urandom,
                             $urandom));
    end
    send_command(make_item(OP_ASSIGN, 32'h0002_0000, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_ASSIGN, 32'h0001_0005, ones, wide, 4, ones, ones, ones,
                           ones));
    send_command(make_item(OP_GET, 32'h0001_0005, 0, 0, 0, 0, 0, 0, 0));
    send_command(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      send_command(random_item());
      if (n == RANDOM_ITEMS / 2) begin
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
